@@ design/svm_pkg.sv @@
// Package for the stack VM execute unit: opcodes, status codes, and the
// command and status structs between controller and datapath. No dependencies.
package svm_pkg;

  typedef enum logic [4:0] {
    OP_LEA  = 5'd0,  OP_IMM = 5'd1,  OP_JMP = 5'd2,  OP_JSR = 5'd3,
    OP_BZ   = 5'd4,  OP_BNZ = 5'd5,  OP_ENT = 5'd6,  OP_ADJ = 5'd7,
    OP_LEV  = 5'd8,  OP_LI  = 5'd9,  OP_LC  = 5'd10, OP_SI  = 5'd11,
    OP_SC   = 5'd12, OP_PSH = 5'd13, OP_OR  = 5'd14, OP_XOR = 5'd15,
    OP_AND  = 5'd16, OP_EQ  = 5'd17, OP_NE  = 5'd18, OP_LT  = 5'd19,
    OP_GT   = 5'd20, OP_LE  = 5'd21, OP_GE  = 5'd22, OP_SHL = 5'd23,
    OP_SHR  = 5'd24, OP_ADD = 5'd25, OP_SUB = 5'd26, OP_MUL = 5'd27,
    OP_DIV  = 5'd28, OP_MOD = 5'd29, OP_PRTF = 5'd30, OP_EXIT = 5'd31
  } op_t;

  typedef enum logic [1:0] {
    ST_RUN = 2'd0, ST_EXIT = 2'd1, ST_DIVZ = 2'd2, ST_UNSUP = 2'd3
  } status_t;

  localparam int unsigned PC_W  = 16;
  localparam int unsigned PTR_W = 17;
  localparam int unsigned WORD_W = 32;

  // Controller to datapath
  typedef struct packed {
    logic latch;     // capture input word
    logic read1;     // first memory read (sp, acc or bp address)
    logic read2;     // second memory read (LEV return address)
    logic div_go;    // start divider
    logic commit;    // update architectural state
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_div;    // latched op is DIV/MOD with nonzero divisor, unit not halted
    logic is_lev;
    logic div_done;
  } dstat_t;

endpackage

@@ design/svm_ram.sv @@
// Generic single-port RAM with registered read. No dependencies.
module svm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ design/svm_div.sv @@
// Radix-2 restoring signed divider, one quotient bit per cycle.
// Depends on svm_pkg.
module svm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [svm_pkg::WORD_W-1:0]  dividend,
  input  logic [svm_pkg::WORD_W-1:0]  divisor,
  output logic                        done,
  output logic [svm_pkg::WORD_W-1:0]  quotient,
  output logic [svm_pkg::WORD_W-1:0]  remainder
);
  localparam int unsigned W = svm_pkg::WORD_W;

  logic [W-1:0] dvd, dvs, quo;
  logic [W:0]   rem;
  logic [5:0]   count;
  logic         busy, neg_q, neg_r;
  logic [W:0]   trial;
  logic [W:0]   shifted;

  assign shifted = {rem[W-1:0], dvd[W-1]};
  assign trial   = shifted - {1'b0, dvs};

  // Iterate over magnitudes, fix signs at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'(W);
        neg_q <= dividend[W-1] ^ divisor[W-1];
        neg_r <= dividend[W-1];
        dvd   <= dividend[W-1] ? (~dividend + 1'b1) : dividend;
        dvs   <= divisor[W-1] ? (~divisor + 1'b1) : divisor;
        rem   <= '0;
        quo   <= '0;
      end else if (busy) begin
        dvd <= {dvd[W-2:0], 1'b0};
        if (!trial[W]) begin
          rem <= trial;
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[W-2:0], 1'b0};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = neg_q ? (~quo + 1'b1) : quo;
  assign remainder = neg_r ? (~rem[W-1:0] + 1'b1) : rem[W-1:0];

  a_done_one: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("divider done held");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("divider restarted while busy");
  a_busy_no_done: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done) else $error("done while still iterating");
endmodule

@@ design/svm_dp.sv @@
// Datapath: architectural registers, memory port, ALU and divider.
// Depends on svm_pkg, svm_ram, svm_div.
module svm_dp #(
  parameter int unsigned MEM_WORDS = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  svm_pkg::cmd_t        cmd,
  output svm_pkg::dstat_t      dstat,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data,
  input  logic [4:0]           in_op,
  input  logic [31:0]          in_imm,
  output logic [15:0]          r_pc,
  output logic [31:0]          r_acc,
  output logic [1:0]           r_status,
  output logic [31:0]          r_exit
);
  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam int unsigned PW = svm_pkg::PTR_W;

  logic [31:0] acc;
  logic [15:0] pc;
  logic [PW-1:0] sp, bp;
  logic        halted;
  logic [1:0]  hstatus;
  svm_pkg::op_t op;
  logic [31:0] imm;
  logic [31:0] l1, l2;  // memory read results
  logic        mwe;
  logic [AW-1:0] maddr;
  logic [31:0] mwdata, mrdata;
  logic        div_done;
  logic [31:0] quo, rem;

  svm_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
    .clk(clk), .we(mwe), .addr(maddr), .wdata(mwdata), .rdata(mrdata));

  svm_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_go), .dividend(l1), .divisor(acc),
    .done(div_done), .quotient(quo), .remainder(rem));

  logic [15:0] pc1, pc2;
  logic [PW-1:0] sp_m1, sp_p1, bp_p1;
  logic [31:0] sext_acc, sext_l1;
  logic signed [31:0] sl, sr;
  logic [31:0] alu;
  logic [31:0] acc_n;
  logic [15:0] pc_n;
  logic [PW-1:0] sp_n, bp_n;
  logic [1:0]  st_n;
  logic [31:0] exit_n;

  assign pc1 = pc + 16'd1;
  assign pc2 = pc + 16'd2;
  assign sp_m1 = sp - 1'b1;
  assign sp_p1 = sp + 1'b1;
  assign bp_p1 = bp + 1'b1;
  assign sext_acc = {{24{acc[7]}}, acc[7:0]};
  assign sext_l1  = {{24{l1[7]}}, l1[7:0]};
  assign sl = l1;
  assign sr = acc;

  // Memory address/write selection; reads are launched by cmd.read1/2
  always_comb begin
    mwe = 1'b0;
    mwdata = acc;
    maddr = sp[AW-1:0];
    if (cmd.read1 && (op == svm_pkg::OP_LI || op == svm_pkg::OP_LC)) begin
      maddr = acc[AW-1:0];
    end else if (cmd.read1 && op == svm_pkg::OP_LEV) begin
      maddr = bp[AW-1:0];
    end else if (cmd.read2) begin
      maddr = bp_p1[AW-1:0];
    end else if (cmd.commit && !halted) begin
      unique case (op)
        svm_pkg::OP_JSR: begin mwe = 1'b1; maddr = sp_m1[AW-1:0]; mwdata = {16'd0, pc2}; end
        svm_pkg::OP_ENT: begin mwe = 1'b1; maddr = sp_m1[AW-1:0]; mwdata = 32'(bp); end
        svm_pkg::OP_PSH: begin mwe = 1'b1; maddr = sp_m1[AW-1:0]; end
        svm_pkg::OP_SI:  begin mwe = 1'b1; maddr = l1[AW-1:0]; end
        svm_pkg::OP_SC:  begin mwe = 1'b1; maddr = l1[AW-1:0]; mwdata = sext_acc; end
        default: ;
      endcase
    end
  end

  // ALU on popped left operand and accumulator
  always_comb begin
    unique case (op)
      svm_pkg::OP_OR:  alu = l1 | acc;
      svm_pkg::OP_XOR: alu = l1 ^ acc;
      svm_pkg::OP_AND: alu = l1 & acc;
      svm_pkg::OP_EQ:  alu = {31'd0, l1 == acc};
      svm_pkg::OP_NE:  alu = {31'd0, l1 != acc};
      svm_pkg::OP_LT:  alu = {31'd0, sl < sr};
      svm_pkg::OP_GT:  alu = {31'd0, sl > sr};
      svm_pkg::OP_LE:  alu = {31'd0, sl <= sr};
      svm_pkg::OP_GE:  alu = {31'd0, sl >= sr};
      svm_pkg::OP_SHL: alu = l1 << acc[4:0];
      svm_pkg::OP_SHR: alu = 32'(sl >>> acc[4:0]);
      svm_pkg::OP_ADD: alu = l1 + acc;
      svm_pkg::OP_SUB: alu = l1 - acc;
      svm_pkg::OP_MUL: alu = l1 * acc;
      svm_pkg::OP_DIV: alu = quo;
      svm_pkg::OP_MOD: alu = rem;
      default:         alu = acc;
    endcase
  end

  // Next architectural state for the latched instruction
  always_comb begin
    acc_n = acc; pc_n = pc1; sp_n = sp; bp_n = bp; st_n = svm_pkg::ST_RUN;
    exit_n = '0;
    unique case (op)
      svm_pkg::OP_LEA: begin acc_n = 32'(bp) + imm; pc_n = pc2; end
      svm_pkg::OP_IMM: begin acc_n = imm; pc_n = pc2; end
      svm_pkg::OP_JMP: pc_n = imm[15:0];
      svm_pkg::OP_JSR: begin sp_n = sp_m1; pc_n = imm[15:0]; end
      svm_pkg::OP_BZ:  pc_n = (acc != 0) ? pc2 : imm[15:0];
      svm_pkg::OP_BNZ: pc_n = (acc != 0) ? imm[15:0] : pc2;
      svm_pkg::OP_ENT: begin bp_n = sp_m1; sp_n = sp_m1 - imm[PW-1:0]; pc_n = pc2; end
      svm_pkg::OP_ADJ: begin sp_n = sp + imm[PW-1:0]; pc_n = pc2; end
      svm_pkg::OP_LEV: begin
        bp_n = l1[PW-1:0]; pc_n = l2[15:0]; sp_n = PW'(bp + 2'd2);
      end
      svm_pkg::OP_LI:  acc_n = l1;
      svm_pkg::OP_LC:  acc_n = sext_l1;
      svm_pkg::OP_SI:  sp_n = sp_p1;
      svm_pkg::OP_SC:  begin sp_n = sp_p1; acc_n = sext_acc; end
      svm_pkg::OP_PSH: sp_n = sp_m1;
      svm_pkg::OP_PRTF: st_n = svm_pkg::ST_UNSUP;
      svm_pkg::OP_EXIT: begin st_n = svm_pkg::ST_EXIT; exit_n = l1; end
      default: begin
        sp_n = sp_p1;
        if ((op == svm_pkg::OP_DIV || op == svm_pkg::OP_MOD) && acc == 0) begin
          st_n = svm_pkg::ST_DIVZ;
        end else begin
          acc_n = alu;
        end
      end
    endcase
  end

  // Capture memory reads
  logic rd1_q, rd2_q;
  always_ff @(posedge clk) begin
    rd1_q <= cmd.read1;
    rd2_q <= cmd.read2;
    if (cmd.latch) begin
      op  <= svm_pkg::op_t'(in_op);
      imm <= in_imm;
    end
    if (rd1_q) l1 <= mrdata;
    if (rd2_q) l2 <= mrdata;
  end

  // Architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0; pc <= '0; sp <= PW'(MEM_WORDS); bp <= PW'(MEM_WORDS);
      halted <= 1'b0; hstatus <= svm_pkg::ST_RUN;
      r_status <= svm_pkg::ST_RUN; r_exit <= '0; r_pc <= '0; r_acc <= '0;
    end else begin
      if (cfg_we) pc <= cfg_data;
      if (cmd.commit) begin
        if (halted) begin
          r_pc <= pc; r_acc <= acc; r_status <= hstatus; r_exit <= '0;
        end else begin
          acc <= acc_n; pc <= pc_n; sp <= sp_n; bp <= bp_n;
          r_pc <= pc_n; r_acc <= acc_n; r_status <= st_n; r_exit <= exit_n;
          if (st_n != svm_pkg::ST_RUN) begin
            halted <= 1'b1; hstatus <= st_n;
          end
        end
      end
    end
  end

  assign dstat.is_div = (op == svm_pkg::OP_DIV || op == svm_pkg::OP_MOD) && acc != 0
                        && !halted;
  assign dstat.is_lev = (op == svm_pkg::OP_LEV);
  assign dstat.div_done = div_done;

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted) else $error("halt flag cleared");
  a_run_status: assert property (@(posedge clk) disable iff (rst)
    !halted |-> hstatus == svm_pkg::ST_RUN) else $error("status without halt");
  a_div_only: assert property (@(posedge clk) disable iff (rst)
    cmd.div_go |-> dstat.is_div) else $error("divider started for non-divide");
endmodule

@@ design/svm_ctrl.sv @@
// Controller FSM: sequences fetch of operands, execute, divide and result.
// Depends on svm_pkg.
module svm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            out_fire,
  input  svm_pkg::dstat_t dstat,
  output svm_pkg::cmd_t   cmd,
  output logic            in_ready,
  output logic            out_valid
);
  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_RD2, S_WAIT, S_DIV, S_COMMIT, S_OUT
  } state_t;

  state_t state;

  // Commands decoded from the current state; the latch strobe follows in_fire
  always_comb begin
    cmd = '0;
    cmd.latch = in_fire;
    unique case (state)
      S_RD1:    cmd.read1 = 1'b1;
      S_RD2:    cmd.read2 = dstat.is_lev;
      S_WAIT:   cmd.div_go = dstat.is_div;
      S_COMMIT: cmd.commit = 1'b1;
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE:   if (in_fire) state <= S_RD1;
        S_RD1:    state <= S_RD2;
        S_RD2:    state <= S_WAIT;
        S_WAIT:   state <= dstat.is_div ? S_DIV : S_COMMIT;
        S_DIV:    if (dstat.div_done) state <= S_COMMIT;
        S_COMMIT: begin state <= S_OUT; out_valid <= 1'b1; end
        S_OUT:    if (out_fire) begin state <= S_IDLE; out_valid <= 1'b0; end
        default:  state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accepting while result pending");
  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid) else $error("commit without result");
  a_valid_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("result valid outside output state");
endmodule

@@ design/stack_vm_execute_unit.sv @@
// Top level of the stack VM execute unit: controller and datapath.
// Depends on svm_pkg, svm_ctrl, svm_dp.
//
// One instruction per input word on s_axis: tdata = {operand, operation}.
// One result word per instruction on m_axis: tdata packs next_address,
// accumulator, status and exit_value. cfg_we/cfg_data write entry_address
// and load the program counter; write only while idle.
// After acceptance the controller passes two memory read slots of the
// registered-read data RAM, a wait slot and commit, then turns the result
// word valid; it is taken while m_axis_tready is high, and the controller
// returns to idle before it accepts the next instruction. DIV and MOD add
// a divide state that waits for the one-bit-per-cycle divider. One
// instruction is in flight at a time: s_axis_tready is low from acceptance
// until the result is taken, so a stalled m_axis_tready holds the block.
// Reset clears accumulator, program counter, halt flag and sets stack
// pointer and frame base to MEM_WORDS; memory contents are undefined.
// After EXIT, PRTF or a divide by zero the unit stays halted and repeats
// its state with the sticky status until reset.
module stack_vm_execute_unit #(
  parameter int unsigned MEM_WORDS = 65536
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_data,       // entry_address
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // [4:0] operation, [36:5] operand, zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [87:0]  m_axis_tdata    // [15:0] next_address, [47:16] accumulator,
                                       // [49:48] status, [81:50] exit_value, pad
);
  svm_pkg::cmd_t   cmd;
  svm_pkg::dstat_t dstat;
  logic in_fire, out_fire;
  logic [15:0] r_pc;
  logic [31:0] r_acc, r_exit;
  logic [1:0]  r_status;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  svm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_fire(out_fire),
    .dstat(dstat), .cmd(cmd), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid));

  svm_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .dstat(dstat), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .in_op(s_axis_tdata[4:0]), .in_imm(s_axis_tdata[36:5]),
    .r_pc(r_pc), .r_acc(r_acc), .r_status(r_status), .r_exit(r_exit));

  assign m_axis_tdata = {6'd0, r_exit, r_status, r_acc, r_pc};
endmodule

@@ bench/tb_stack_vm_execute_unit.sv @@
// Self-checking testbench for stack_vm_execute_unit: streams instruction words,
// predicts each result word with its own machine model and compares them.
// Depends on svm_pkg and the stack_vm_execute_unit RTL.
module tb_stack_vm_execute_unit;

  typedef struct {
    svm_pkg::op_t     op;
    logic [31:0]      imm;
    logic [15:0]      pc;
    logic [31:0]      acc;
    svm_pkg::status_t st;
    logic [31:0]      xv;
  } instr_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // [4:0] operation, [36:5] operand, pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;       // [15:0] next_address, [47:16] accumulator,
                                   // [49:48] status, [81:50] exit_value, pad

  // Machine model state
  logic [31:0]      vm_acc;
  logic [15:0]      vm_pc;
  logic [16:0]      vm_sp, vm_fb;
  logic [31:0]      vm_mem [int];
  int               vm_addrs [$];
  logic             vm_halted;
  svm_pkg::status_t vm_halt_st;

  instr_t      words_to_send [$];
  instr_t      words_in_flight [$];
  instr_t      sending;
  int          issued_cnt, checked_cnt, accepted_cnt, errors, div_cnt, call_cnt;
  int unsigned send_idle_pct, recv_idle_pct;
  logic        recv_hold;

  stack_vm_execute_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stack helpers of the model; addresses wrap to the 64K-word memory
  task automatic vm_store(input logic [15:0] a, input logic [31:0] v);
    if (!vm_mem.exists(a)) vm_addrs.push_back(a);
    vm_mem[a] = v;
  endtask

  task automatic vm_push(input logic [31:0] v);
    vm_sp = vm_sp - 17'd1;
    vm_store(vm_sp[15:0], v);
  endtask

  task automatic vm_pop(output logic [31:0] v);
    v = vm_mem[vm_sp[15:0]];
    vm_sp = vm_sp + 17'd1;
  endtask

  // Execute one instruction in the model and queue the word with its result
  task automatic exec_instr(input svm_pkg::op_t op, input logic [31:0] imm);
    logic [15:0] pc1, pc2;
    logic [31:0] l, r, t;
    instr_t w;
    pc1 = vm_pc + 16'd1;
    pc2 = vm_pc + 16'd2;
    r = vm_acc;
    w.st = svm_pkg::ST_RUN;
    w.xv = '0;
    if (vm_halted) begin
      w.st = vm_halt_st;
    end else begin
      case (op)
        svm_pkg::OP_LEA: begin vm_acc = {15'd0, vm_fb} + imm; vm_pc = pc2; end
        svm_pkg::OP_IMM: begin vm_acc = imm; vm_pc = pc2; end
        svm_pkg::OP_JMP: vm_pc = imm[15:0];
        svm_pkg::OP_JSR: begin vm_push({16'd0, pc2}); vm_pc = imm[15:0]; end
        svm_pkg::OP_BZ:  vm_pc = (vm_acc != 0) ? pc2 : imm[15:0];
        svm_pkg::OP_BNZ: vm_pc = (vm_acc != 0) ? imm[15:0] : pc2;
        svm_pkg::OP_ENT: begin
          vm_push({15'd0, vm_fb});
          vm_fb = vm_sp;
          vm_sp = vm_sp - imm[16:0];
          vm_pc = pc2;
        end
        svm_pkg::OP_ADJ: begin vm_sp = vm_sp + imm[16:0]; vm_pc = pc2; end
        svm_pkg::OP_LEV: begin
          vm_sp = vm_fb;
          vm_pop(t);
          vm_fb = t[16:0];
          vm_pop(t);
          vm_pc = t[15:0];
        end
        svm_pkg::OP_LI: begin vm_acc = vm_mem[vm_acc[15:0]]; vm_pc = pc1; end
        svm_pkg::OP_LC: begin
          t = vm_mem[vm_acc[15:0]];
          vm_acc = {{24{t[7]}}, t[7:0]};
          vm_pc = pc1;
        end
        svm_pkg::OP_SI: begin vm_pop(l); vm_store(l[15:0], vm_acc); vm_pc = pc1; end
        svm_pkg::OP_SC: begin
          vm_pop(l);
          vm_acc = {{24{vm_acc[7]}}, vm_acc[7:0]};
          vm_store(l[15:0], vm_acc);
          vm_pc = pc1;
        end
        svm_pkg::OP_PSH: begin vm_push(vm_acc); vm_pc = pc1; end
        svm_pkg::OP_PRTF: begin
          w.st = svm_pkg::ST_UNSUP; vm_halted = 1'b1; vm_halt_st = svm_pkg::ST_UNSUP;
          vm_pc = pc1;
        end
        svm_pkg::OP_EXIT: begin
          w.xv = vm_mem[vm_sp[15:0]];
          w.st = svm_pkg::ST_EXIT; vm_halted = 1'b1; vm_halt_st = svm_pkg::ST_EXIT;
          vm_pc = pc1;
        end
        default: begin
          // binary ops: left operand popped, right operand is the accumulator
          vm_pop(l);
          vm_pc = pc1;
          case (op)
            svm_pkg::OP_OR:  vm_acc = l | r;
            svm_pkg::OP_XOR: vm_acc = l ^ r;
            svm_pkg::OP_AND: vm_acc = l & r;
            svm_pkg::OP_EQ:  vm_acc = {31'd0, l == r};
            svm_pkg::OP_NE:  vm_acc = {31'd0, l != r};
            svm_pkg::OP_LT:  vm_acc = {31'd0, $signed(l) < $signed(r)};
            svm_pkg::OP_GT:  vm_acc = {31'd0, $signed(l) > $signed(r)};
            svm_pkg::OP_LE:  vm_acc = {31'd0, $signed(l) <= $signed(r)};
            svm_pkg::OP_GE:  vm_acc = {31'd0, $signed(l) >= $signed(r)};
            svm_pkg::OP_SHL: vm_acc = l << r[4:0];
            svm_pkg::OP_SHR: vm_acc = $signed(l) >>> r[4:0];
            svm_pkg::OP_ADD: vm_acc = l + r;
            svm_pkg::OP_SUB: vm_acc = l - r;
            svm_pkg::OP_MUL: vm_acc = l * r;
            default: begin
              div_cnt++;
              if (r == 0) begin
                w.st = svm_pkg::ST_DIVZ; vm_halted = 1'b1; vm_halt_st = svm_pkg::ST_DIVZ;
              end else if (l == 32'h8000_0000 && r == 32'hFFFF_FFFF) begin
                // most negative / -1 wraps, remainder zero
                vm_acc = (op == svm_pkg::OP_DIV) ? l : 32'd0;
              end else if (op == svm_pkg::OP_DIV) begin
                vm_acc = $signed(l) / $signed(r);
              end else begin
                vm_acc = $signed(l) % $signed(r);
              end
            end
          endcase
        end
      endcase
    end
    w.op = op;
    w.imm = imm;
    w.pc = vm_pc;
    w.acc = vm_acc;
    words_to_send.push_back(w);
    issued_cnt++;
  endtask

  // Make the top of stack readable by pushing the accumulator
  task automatic fill_top();
    if (!vm_mem.exists(vm_sp[15:0])) exec_instr(svm_pkg::OP_PSH, $urandom);
  endtask

  // Issue one instruction, first issuing whatever keeps every memory read
  // on a written word; a zero divisor is avoided unless a halt is wanted
  task automatic issue(input svm_pkg::op_t op, input logic [31:0] imm,
                       input bit may_halt);
    logic [31:0] a;
    if (vm_halted) begin
      exec_instr(op, imm);
    end else begin
      if ((op == svm_pkg::OP_DIV || op == svm_pkg::OP_MOD) && vm_acc == 0 && !may_halt)
        exec_instr(svm_pkg::OP_IMM, $urandom | 32'd1);
      if (op == svm_pkg::OP_LEV && !(vm_mem.exists(vm_fb[15:0]) &&
                                     vm_mem.exists(vm_fb[15:0] + 16'd1))) begin
        exec_instr(svm_pkg::OP_JSR, $urandom);
        exec_instr(svm_pkg::OP_ENT, $urandom_range(0, 6));
      end
      if (op == svm_pkg::OP_LI || op == svm_pkg::OP_LC) begin
        if (vm_addrs.size() == 0) exec_instr(svm_pkg::OP_PSH, $urandom);
        if (!vm_mem.exists(vm_acc[15:0])) begin
          a = vm_addrs[$urandom_range(0, vm_addrs.size() - 1)];
          exec_instr(svm_pkg::OP_IMM, {16'($urandom_range(0, 16'hFFFF)), a[15:0]});
        end
      end
      if (op == svm_pkg::OP_SI || op == svm_pkg::OP_SC || op == svm_pkg::OP_EXIT ||
          (op >= svm_pkg::OP_OR && op <= svm_pkg::OP_MOD))
        fill_top();
      exec_instr(op, imm);
    end
  endtask

  // Random operand: mostly small, sometimes full width
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 40) - 20;
      2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom_range(0, 3))};
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  task automatic random_instr();
    svm_pkg::op_t op;
    logic [31:0] imm;
    op = svm_pkg::op_t'($urandom_range(svm_pkg::OP_LEA, svm_pkg::OP_MOD));
    imm = (op == svm_pkg::OP_ENT && $urandom_range(0, 7) != 0) ?
          $urandom_range(0, 12) : rand_operand();
    issue(op, imm, 1'b0);
  endtask

  // Call frame: JSR, ENT, a short body, LEV
  task automatic call_frame();
    int n;
    call_cnt++;
    issue(svm_pkg::OP_JSR, $urandom, 1'b0);
    issue(svm_pkg::OP_ENT, $urandom_range(0, 8), 1'b0);
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(0, 4))
        0: issue(svm_pkg::OP_LEA, $urandom_range(0, 8) - 4, 1'b0);
        1: issue(svm_pkg::OP_PSH, $urandom, 1'b0);
        2: issue(svm_pkg::OP_IMM, $urandom, 1'b0);
        3: issue(svm_pkg::OP_LI, $urandom, 1'b0);
        default: issue(svm_pkg::op_t'($urandom_range(svm_pkg::OP_OR, svm_pkg::OP_MOD)),
                       $urandom, 1'b0);
      endcase
    end
    issue(svm_pkg::OP_LEV, $urandom, 1'b0);
  endtask

  task automatic random_run(input int n);
    int stop;
    stop = issued_cnt + n;
    while (issued_cnt < stop) begin
      if ($urandom_range(0, 4) == 0) call_frame();
      else random_instr();
    end
  endtask

  // Let every word drain, then a few cycles more
  task automatic drain();
    while (checked_cnt != issued_cnt) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_entry(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    vm_pc = v;
  endtask

  // Driver: where the slot frees up, offers the next pending word or, at random, idles
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        words_in_flight.push_back(sending);
        accepted_cnt++;
      end
      if (words_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        sending = words_to_send.pop_front();
        s_axis_tdata <= {3'd0, sending.imm, sending.op};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: random backpressure, compare each result word with the oldest one due
  always @(posedge clk) begin
    instr_t e;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (words_in_flight.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h", m_axis_tdata);
        end else begin
          e = words_in_flight.pop_front();
          checked_cnt++;
          if (m_axis_tdata[15:0] !== e.pc || m_axis_tdata[47:16] !== e.acc ||
              m_axis_tdata[49:48] !== e.st || m_axis_tdata[81:50] !== e.xv) begin
            errors++;
            if (errors <= 10)
              $display("%s %h: exp pc %h acc %h st %0d xv %h, got pc %h acc %h st %0d xv %h",
                       e.op.name(), e.imm, e.pc, e.acc, e.st, e.xv, m_axis_tdata[15:0],
                       m_axis_tdata[47:16], m_axis_tdata[49:48], m_axis_tdata[81:50]);
          end
        end
      end
      m_axis_tready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off while the sender keeps offering
  initial begin
    recv_hold = 1'b0;
    wait (accepted_cnt >= 300);
    @(posedge clk);
    recv_hold = 1'b1;
    repeat (400) @(posedge clk);
    recv_hold = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("stack_vm_execute_unit: mismatch");
    $finish;
  end

  // Stimulus and phases
  initial begin
    int k;
    issued_cnt = 0; checked_cnt = 0; accepted_cnt = 0; errors = 0;
    div_cnt = 0; call_cnt = 0;
    send_idle_pct = 21; recv_idle_pct = 66;
    vm_acc = '0; vm_pc = '0; vm_sp = 17'h10000; vm_fb = 17'h10000;
    vm_halted = 1'b0; vm_halt_st = svm_pkg::ST_RUN;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_entry(16'd0);

    // directed: field extremes, every non-halting opcode, wrap cases
    issue(svm_pkg::OP_IMM, 32'h7FFF_FFFF, 1'b0);
    issue(svm_pkg::OP_PSH, 0, 1'b0);
    issue(svm_pkg::OP_IMM, 32'h8000_0000, 1'b0);
    issue(svm_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b0);
    issue(svm_pkg::OP_IMM, 32'h8000_0000, 1'b0);
    issue(svm_pkg::OP_PSH, 0, 1'b0);
    issue(svm_pkg::OP_IMM, 32'hFFFF_FFFF, 1'b0);
    issue(svm_pkg::OP_DIV, 0, 1'b0);
    issue(svm_pkg::OP_PSH, 0, 1'b0);
    issue(svm_pkg::OP_IMM, 32'hFFFF_FFFF, 1'b0);
    issue(svm_pkg::OP_MOD, 0, 1'b0);
    issue(svm_pkg::OP_BZ, 32'h0000_1234, 1'b0);
    issue(svm_pkg::OP_BNZ, 32'hFFFF_0042, 1'b0);
    issue(svm_pkg::OP_IMM, 32'd1, 1'b0);
    issue(svm_pkg::OP_BZ, 32'hFFFF_FFFF, 1'b0);
    issue(svm_pkg::OP_BNZ, 32'h0001_FFFF, 1'b0);
    issue(svm_pkg::OP_SC, 0, 1'b0);
    issue(svm_pkg::OP_LC, 0, 1'b0);
    for (k = svm_pkg::OP_LEA; k <= svm_pkg::OP_MOD; k++)
      issue(svm_pkg::op_t'(k), (k % 2) ? 32'hFFFF_FFFF : 32'd0, 1'b0);
    issue(svm_pkg::OP_ADJ, 32'h8000_0000, 1'b0);
    issue(svm_pkg::OP_SHR, 32'd0, 1'b0);

    random_run(640);
    drain();

    send_idle_pct = 66; recv_idle_pct = 21;
    write_entry(16'hFFFF);
    random_run(660);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_entry(16'($urandom));
    random_run(660);

    // one halting case per run, then words answered with the sticky status
    case ($urandom_range(0, 2))
      0: issue(svm_pkg::OP_EXIT, $urandom, 1'b1);
      1: issue(svm_pkg::OP_PRTF, $urandom, 1'b1);
      default: begin
        issue(svm_pkg::OP_IMM, 32'd0, 1'b1);
        issue($urandom_range(0, 1) ? svm_pkg::OP_DIV : svm_pkg::OP_MOD, $urandom, 1'b1);
      end
    endcase
    repeat (6)
      exec_instr(svm_pkg::op_t'($urandom_range(svm_pkg::OP_LEA, svm_pkg::OP_EXIT)),
                 $urandom);
    drain();
    repeat (40) @(posedge clk);

    $display("%0d instruction words checked, %0d call frames, %0d divides/modulos,",
             checked_cnt, call_cnt, div_cnt);
    $display("three entry addresses, three idle profiles, one halt; %0d errors", errors);
    if (errors == 0 && words_in_flight.size() == 0) begin
      $display("stack_vm_execute_unit: match");
    end else begin
      $display("stack_vm_execute_unit: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/svm_pkg.sv
design/svm_ram.sv
design/svm_div.sv
design/svm_dp.sv
design/svm_ctrl.sv
design/stack_vm_execute_unit.sv
bench/tb_stack_vm_execute_unit.sv
